### hdl/pti_pkg.sv
// Shared constants, types and the arctangent table of the planar twist integrator.
// Depends on nothing; every other file of the block imports it.
package pti_pkg;

  // Field and fixed-point formats
  localparam int FIELD_BITS   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int TRIG_BITS    = 30;
  localparam int ANG_SHIFT    = TRIG_BITS - FRAC_BITS;
  localparam int ANG_BITS     = FIELD_BITS + ANG_SHIFT;
  localparam int RED_BITS     = 36;
  localparam int CORD_BITS    = 34;
  localparam int NUM_BITS     = 64;
  localparam int DEN_BITS     = ANG_BITS;
  localparam int QUO_BITS     = FIELD_BITS + 1;
  localparam int BAND_BITS    = 16;
  localparam int REDUCE_STEPS = 13;
  localparam int CORDIC_STEPS_DEF = 20;

  // Q30 constants
  localparam logic [ANG_BITS-1:0] TWO_PI_MAG = ANG_BITS'(64'd6746518852);
  localparam logic signed [RED_BITS-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [RED_BITS-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [RED_BITS-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CORD_BITS-1:0] GAIN_Q30   = 34'sd652032874;
  localparam logic signed [CORD_BITS:0]   ONE_Q30    = 35'sd1073741824;

  // Word that rides along with each twist through every stage
  typedef struct packed {
    logic                         bypass;
    logic signed [FIELD_BITS-1:0] w;
    logic signed [FIELD_BITS-1:0] x;
    logic signed [FIELD_BITS-1:0] y;
  } side_t;

  typedef struct packed {
    logic                neg;
    logic [ANG_BITS-1:0] mag;
  } red_t;

  typedef struct packed {
    logic                        flip;
    logic signed [CORD_BITS-1:0] cx;
    logic signed [CORD_BITS-1:0] cy;
    logic signed [CORD_BITS-1:0] z;
  } cord_t;

  typedef struct packed {
    logic                neg_x;
    logic                neg_y;
    logic [NUM_BITS-1:0] rem_x;
    logic [NUM_BITS-1:0] rem_y;
    logic [QUO_BITS-1:0] q_x;
    logic [QUO_BITS-1:0] q_y;
    logic [DEN_BITS-1:0] d;
  } div_t;

  // Arctangent of 2^-i in Q30, truncated for i up to 26 and rounded above
  function automatic logic [CORD_BITS-1:0] atan_q30(input int idx);
    logic [CORD_BITS-1:0] v;
    unique case (idx)
      0:  v = 34'd843314856;
      1:  v = 34'd497837829;
      2:  v = 34'd263043836;
      3:  v = 34'd133525158;
      4:  v = 34'd67021686;
      5:  v = 34'd33543515;
      6:  v = 34'd16775850;
      7:  v = 34'd8388437;
      8:  v = 34'd4194282;
      9:  v = 34'd2097149;
      10: v = 34'd1048575;
      11: v = 34'd524287;
      12: v = 34'd262143;
      13: v = 34'd131071;
      14: v = 34'd65535;
      15: v = 34'd32767;
      16: v = 34'd16383;
      17: v = 34'd8191;
      18: v = 34'd4095;
      19: v = 34'd2047;
      20: v = 34'd1023;
      21: v = 34'd511;
      22: v = 34'd255;
      23: v = 34'd127;
      24: v = 34'd63;
      25: v = 34'd31;
      26: v = 34'd15;
      27: v = 34'd8;
      28: v = 34'd4;
      29: v = 34'd2;
      30: v = 34'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/planar_twist_integrator.sv
// Top level of the planar twist integrator (SE(2) exponential map).
// Depends on pti_pkg, pti_reduce_cell, pti_cordic_cell and pti_div_cell.

// Takes one twist word per cycle and returns one pose word per cycle, in order,
// whenever the output is not stalled. Stages: one input register, 13 angle
// reduction cells, two fold stages, one CORDIC cell per iteration, sign fix,
// multiply, sum, magnitude, 33 divider cells and the output register. The whole
// pipeline moves together; while an output word is stalled, in_stall is high and
// nothing advances. zero_band may be written at any time the block is idle;
// cfg_ready is always high.
module planar_twist_integrator #(
  parameter int CORDIC_STEPS = pti_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pti_pkg::BAND_BITS-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [pti_pkg::FIELD_BITS-1:0]  twist_w,
  input  logic signed [pti_pkg::FIELD_BITS-1:0]  twist_x,
  input  logic signed [pti_pkg::FIELD_BITS-1:0]  twist_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pti_pkg::FIELD_BITS-1:0]  pose_theta,
  output logic signed [pti_pkg::FIELD_BITS-1:0]  pose_x,
  output logic signed [pti_pkg::FIELD_BITS-1:0]  pose_y
);
  import pti_pkg::*;

  localparam logic [QUO_BITS-1:0] Q_HALF = QUO_BITS'(1) << (FIELD_BITS - 1);

  logic                  adv;
  logic [BAND_BITS-1:0]  zero_band;

  logic [FIELD_BITS-1:0] in_mag;

  logic  red_vld  [0:REDUCE_STEPS];
  side_t red_side [0:REDUCE_STEPS];
  red_t  red_dat  [0:REDUCE_STEPS];

  logic signed [RED_BITS-1:0] fold_in;
  logic signed [RED_BITS-1:0] fold_next;
  logic                       fold_vld;
  side_t                      fold_side;
  logic signed [RED_BITS-1:0] fold;
  cord_t                      quad_next;

  logic  cor_vld  [0:CORDIC_STEPS];
  side_t cor_side [0:CORDIC_STEPS];
  cord_t cor_dat  [0:CORDIC_STEPS];

  logic signed [CORD_BITS-1:0] sin_next;
  logic signed [CORD_BITS-1:0] cos_next;
  logic                        trig_vld;
  side_t                       trig_side;
  logic signed [CORD_BITS-1:0] sin_q;
  logic signed [CORD_BITS:0]   cm1_q;
  logic signed [CORD_BITS:0]   omc_q;

  logic                        mul_vld;
  side_t                       mul_side;
  logic signed [NUM_BITS-1:0]  p_xs;
  logic signed [NUM_BITS-1:0]  p_yc;
  logic signed [NUM_BITS-1:0]  p_xc;
  logic signed [NUM_BITS-1:0]  p_ys;

  logic                        sum_vld;
  side_t                       sum_side;
  logic signed [NUM_BITS-1:0]  num_x;
  logic signed [NUM_BITS-1:0]  num_y;

  logic [FIELD_BITS-1:0] w_mag;
  div_t                  div_init;

  logic  div_vld  [0:QUO_BITS];
  side_t div_side [0:QUO_BITS];
  div_t  div_dat  [0:QUO_BITS];

  logic signed [FIELD_BITS-1:0] res_x;
  logic signed [FIELD_BITS-1:0] res_y;
  side_t                        last_side;
  div_t                         last_div;

  // Advance the whole pipeline unless the output word is held
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_band <= '0;
    end else if (cfg_valid && cfg_ready) begin
      zero_band <= cfg_data;
    end
  end

  // Input register: zero band test and angle magnitude
  assign in_mag = twist_w[FIELD_BITS-1] ? FIELD_BITS'(-twist_w) : FIELD_BITS'(twist_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_vld[0] <= 1'b0;
    end else if (adv) begin
      red_vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_side[0].bypass <= (in_mag <= FIELD_BITS'(zero_band));
      red_side[0].w      <= twist_w;
      red_side[0].x      <= twist_x;
      red_side[0].y      <= twist_y;
      red_dat[0].neg     <= twist_w[FIELD_BITS-1];
      red_dat[0].mag     <= {in_mag, ANG_SHIFT'(0)};
    end
  end

  // Angle reduction chain, largest multiple of 2*pi first
  for (genvar j = 0; j < REDUCE_STEPS; j++) begin : g_red
    pti_reduce_cell #(.K(REDUCE_STEPS - 1 - j)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .vld_i  (red_vld[j]),
      .side_i (red_side[j]),
      .red_i  (red_dat[j]),
      .vld_o  (red_vld[j+1]),
      .side_o (red_side[j+1]),
      .red_o  (red_dat[j+1])
    );
  end

  // Fold the remainder into [-pi, pi]
  always_comb begin
    fold_in = red_dat[REDUCE_STEPS].neg ?
              -$signed(RED_BITS'(red_dat[REDUCE_STEPS].mag)) :
               $signed(RED_BITS'(red_dat[REDUCE_STEPS].mag));
    fold_next = fold_in;
    if (fold_in > PI_Q30) begin
      fold_next = fold_in - TWO_PI_Q30;
    end else if (fold_in < -PI_Q30) begin
      fold_next = fold_in + TWO_PI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_vld <= 1'b0;
    end else if (adv) begin
      fold_vld <= red_vld[REDUCE_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fold_side <= red_side[REDUCE_STEPS];
      fold      <= fold_next;
    end
  end

  // Fold into [-pi/2, pi/2] and seed the CORDIC
  always_comb begin
    quad_next.flip = 1'b0;
    quad_next.cx   = GAIN_Q30;
    quad_next.cy   = '0;
    quad_next.z    = CORD_BITS'(fold);
    if (fold > HALF_PI_Q30) begin
      quad_next.z    = CORD_BITS'(fold - PI_Q30);
      quad_next.flip = 1'b1;
    end else if (fold < -HALF_PI_Q30) begin
      quad_next.z    = CORD_BITS'(fold + PI_Q30);
      quad_next.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cor_vld[0] <= 1'b0;
    end else if (adv) begin
      cor_vld[0] <= fold_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cor_side[0] <= fold_side;
      cor_dat[0]  <= quad_next;
    end
  end

  // CORDIC chain, one iteration per cell
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    pti_cordic_cell #(.STEP(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .vld_i  (cor_vld[i]),
      .side_i (cor_side[i]),
      .cord_i (cor_dat[i]),
      .vld_o  (cor_vld[i+1]),
      .side_o (cor_side[i+1]),
      .cord_o (cor_dat[i+1])
    );
  end

  // Undo the half-turn fold and form cos - 1, 1 - cos
  assign sin_next = cor_dat[CORDIC_STEPS].flip ? -cor_dat[CORDIC_STEPS].cy
                                               :  cor_dat[CORDIC_STEPS].cy;
  assign cos_next = cor_dat[CORDIC_STEPS].flip ? -cor_dat[CORDIC_STEPS].cx
                                               :  cor_dat[CORDIC_STEPS].cx;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_vld <= 1'b0;
      mul_vld  <= 1'b0;
      sum_vld  <= 1'b0;
      div_vld[0] <= 1'b0;
    end else if (adv) begin
      trig_vld <= cor_vld[CORDIC_STEPS];
      mul_vld  <= trig_vld;
      sum_vld  <= mul_vld;
      div_vld[0] <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trig_side <= cor_side[CORDIC_STEPS];
      sin_q     <= sin_next;
      cm1_q     <= (CORD_BITS+1)'(cos_next) - ONE_Q30;
      omc_q     <= ONE_Q30 - (CORD_BITS+1)'(cos_next);
    end
  end

  // Products, exact in 64 bits after summing
  always_ff @(posedge clk) begin
    if (adv) begin
      mul_side <= trig_side;
      p_xs     <= NUM_BITS'(trig_side.x) * NUM_BITS'(sin_q);
      p_yc     <= NUM_BITS'(trig_side.y) * NUM_BITS'(cm1_q);
      p_xc     <= NUM_BITS'(trig_side.x) * NUM_BITS'(omc_q);
      p_ys     <= NUM_BITS'(trig_side.y) * NUM_BITS'(sin_q);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_side <= mul_side;
      num_x    <= p_xs + p_yc;
      num_y    <= p_xc + p_ys;
    end
  end

  // Split numerators and denominator into sign and magnitude
  assign w_mag = sum_side.w[FIELD_BITS-1] ? FIELD_BITS'(-sum_side.w)
                                          : FIELD_BITS'(sum_side.w);

  always_comb begin
    div_init.neg_x = num_x[NUM_BITS-1] ^ sum_side.w[FIELD_BITS-1];
    div_init.neg_y = num_y[NUM_BITS-1] ^ sum_side.w[FIELD_BITS-1];
    div_init.rem_x = num_x[NUM_BITS-1] ? NUM_BITS'(-num_x) : NUM_BITS'(num_x);
    div_init.rem_y = num_y[NUM_BITS-1] ? NUM_BITS'(-num_y) : NUM_BITS'(num_y);
    div_init.q_x   = '0;
    div_init.q_y   = '0;
    div_init.d     = {w_mag, ANG_SHIFT'(0)};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_side[0] <= sum_side;
      div_dat[0]  <= div_init;
    end
  end

  // Divider chain, most significant quotient bit first
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    pti_div_cell #(.K(QUO_BITS - 1 - k)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .vld_i  (div_vld[k]),
      .side_i (div_side[k]),
      .div_i  (div_dat[k]),
      .vld_o  (div_vld[k+1]),
      .side_o (div_side[k+1]),
      .div_o  (div_dat[k+1])
    );
  end

  // Apply sign and saturate
  assign last_side = div_side[QUO_BITS];
  assign last_div  = div_dat[QUO_BITS];

  always_comb begin
    if (last_div.neg_x) begin
      res_x = (last_div.q_x > Q_HALF) ? {1'b1, (FIELD_BITS-1)'(0)}
                                      : -$signed(last_div.q_x[FIELD_BITS-1:0]);
    end else begin
      res_x = (last_div.q_x >= Q_HALF) ? {1'b0, {(FIELD_BITS-1){1'b1}}}
                                       : $signed(last_div.q_x[FIELD_BITS-1:0]);
    end
    if (last_div.neg_y) begin
      res_y = (last_div.q_y > Q_HALF) ? {1'b1, (FIELD_BITS-1)'(0)}
                                      : -$signed(last_div.q_y[FIELD_BITS-1:0]);
    end else begin
      res_y = (last_div.q_y >= Q_HALF) ? {1'b0, {(FIELD_BITS-1){1'b1}}}
                                       : $signed(last_div.q_y[FIELD_BITS-1:0]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_vld[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pose_theta <= last_side.bypass ? '0 : last_side.w;
      pose_x     <= last_side.bypass ? last_side.x : res_x;
      pose_y     <= last_side.bypass ? last_side.y : res_y;
    end
  end

  // Reduced angle stays below one full turn
  a_reduce_range: assert property (@(posedge clk) disable iff (rst)
    red_vld[REDUCE_STEPS] |-> (red_dat[REDUCE_STEPS].mag < TWO_PI_MAG))
    else $error("angle reduction left a full turn");

  // Seeded CORDIC angle lies within a quarter turn
  a_quad_range: assert property (@(posedge clk) disable iff (rst)
    cor_vld[0] |-> ($signed(RED_BITS'(cor_dat[0].z)) <= HALF_PI_Q30 &&
                    $signed(RED_BITS'(cor_dat[0].z)) >= -HALF_PI_Q30))
    else $error("CORDIC seed angle out of range");

  // Without quotient overflow the remainder ends below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (div_vld[QUO_BITS] && !last_side.bypass && !last_div.q_x[QUO_BITS-1]) |->
      (last_div.rem_x < NUM_BITS'(last_div.d)))
    else $error("divider remainder not reduced");

endmodule

### hdl/pti_reduce_cell.sv
// One cell of the angle reduction chain: conditional subtract of 2*pi << K.
// Depends on pti_pkg.
module pti_reduce_cell #(
  parameter int K = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          vld_i,
  input  pti_pkg::side_t side_i,
  input  pti_pkg::red_t  red_i,
  output logic          vld_o,
  output pti_pkg::side_t side_o,
  output pti_pkg::red_t  red_o
);
  import pti_pkg::*;

  localparam logic [ANG_BITS-1:0] STEP_VAL = TWO_PI_MAG << K;

  red_t red_next;

  // Subtract the step when it fits
  always_comb begin
    red_next = red_i;
    if (red_i.mag >= STEP_VAL) begin
      red_next.mag = red_i.mag - STEP_VAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_o <= side_i;
      red_o  <= red_next;
    end
  end

endmodule

### hdl/pti_cordic_cell.sv
// One rotation-mode CORDIC iteration, registered.
// Depends on pti_pkg for the word types and the arctangent table.
module pti_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           vld_i,
  input  pti_pkg::side_t side_i,
  input  pti_pkg::cord_t cord_i,
  output logic           vld_o,
  output pti_pkg::side_t side_o,
  output pti_pkg::cord_t cord_o
);
  import pti_pkg::*;

  localparam logic signed [CORD_BITS-1:0] ATAN = $signed(atan_q30(STEP));

  cord_t cord_next;

  // Rotate toward zero residual angle; zero counts as positive
  always_comb begin
    cord_next = cord_i;
    if (!cord_i.z[CORD_BITS-1]) begin
      cord_next.cx = cord_i.cx - (cord_i.cy >>> STEP);
      cord_next.cy = cord_i.cy + (cord_i.cx >>> STEP);
      cord_next.z  = cord_i.z - ATAN;
    end else begin
      cord_next.cx = cord_i.cx + (cord_i.cy >>> STEP);
      cord_next.cy = cord_i.cy - (cord_i.cx >>> STEP);
      cord_next.z  = cord_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_o <= side_i;
      cord_o <= cord_next;
    end
  end

endmodule

### hdl/pti_div_cell.sv
// One restoring division step for both translation lanes: quotient bit K.
// Depends on pti_pkg.
module pti_div_cell #(
  parameter int K = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          vld_i,
  input  pti_pkg::side_t side_i,
  input  pti_pkg::div_t  div_i,
  output logic          vld_o,
  output pti_pkg::side_t side_o,
  output pti_pkg::div_t  div_o
);
  import pti_pkg::*;

  localparam int CW = DEN_BITS + QUO_BITS;

  logic [CW-1:0] sub;
  div_t          div_next;

  // Subtract the shifted divisor from each remainder where it fits
  always_comb begin
    sub      = CW'(div_i.d) << K;
    div_next = div_i;
    if (CW'(div_i.rem_x) >= sub) begin
      div_next.rem_x  = div_i.rem_x - sub[NUM_BITS-1:0];
      div_next.q_x[K] = 1'b1;
    end
    if (CW'(div_i.rem_y) >= sub) begin
      div_next.rem_y  = div_i.rem_y - sub[NUM_BITS-1:0];
      div_next.q_y[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_o <= side_i;
      div_o  <= div_next;
    end
  end

endmodule

### tb/sv/tb_planar_twist_integrator.sv
// Self-checking testbench for planar_twist_integrator (SE(2) exponential map).
// Depends on pti_pkg and the block RTL; predicts each pose in Q16.16 and compares per field.
`timescale 1ns / 100ps

module tb_planar_twist_integrator;
  import pti_pkg::*;

  localparam int LATENCY = 74;
  localparam longint TWO_PI = 64'sd6746518852;
  localparam longint PI = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint GAIN = 64'sd652032874;
  localparam longint ONE = 64'sd1073741824;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] theta;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [BAND_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] twist_w = '0;
  logic signed [31:0] twist_x = '0;
  logic signed [31:0] twist_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pose_theta, pose_x, pose_y;

  logic [15:0] band = '0;
  pose_t pose_q[$];
  int errors = 0;
  bit calm = 1'b0;

  planar_twist_integrator u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .twist_w(twist_w), .twist_x(twist_x), .twist_y(twist_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .pose_theta(pose_theta), .pose_x(pose_x), .pose_y(pose_y)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  // Compute the exponential map of one twist with the current zero band
  function automatic pose_t predict_pose(longint w, longint x, longint y);
    pose_t p;
    longint ang, cx, cy, z, dx, dy, s, c, den, nx, ny, aw;
    bit flip;
    aw = (w < 0) ? -w : w;
    if (aw <= longint'(band)) begin
      p.theta = '0;
      p.x = x[31:0];
      p.y = y[31:0];
      return p;
    end
    den = w * 64'sd16384;
    // reduce modulo 2*pi toward zero, fold into [-pi, pi] then [-pi/2, pi/2]
    ang = den % TWO_PI;
    if (ang > PI) ang -= TWO_PI;
    else if (ang < -PI) ang += TWO_PI;
    flip = 1'b0;
    if (ang > HALF_PI) begin
      ang -= PI;
      flip = 1'b1;
    end else if (ang < -HALF_PI) begin
      ang += PI;
      flip = 1'b1;
    end
    cx = GAIN;
    cy = 0;
    z = ang;
    for (int i = 0; i < 20; i++) begin
      dx = shr(cy, i);
      dy = shr(cx, i);
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= longint'(atan_q30(i));
      end else begin
        cx += dx; cy -= dy; z += longint'(atan_q30(i));
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    s = cy;
    c = cx;
    nx = x * s + y * (c - ONE);
    ny = x * (ONE - c) + y * s;
    p.theta = w[31:0];
    p.x = 32'(clamp(nx / den));
    p.y = 32'(clamp(ny / den));
    return p;
  endfunction

  // Present one twist word and hold it until accepted
  task automatic send_twist(logic signed [31:0] w, logic signed [31:0] x,
                            logic signed [31:0] y);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    twist_w <= w;
    twist_x <= x;
    twist_y <= y;
    pose_q.push_back(predict_pose(longint'(w), longint'(x), longint'(y)));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Write the zero band while the pipeline is empty
  task automatic write_band(logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    band = v;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed(32'($urandom_range(65535))) - 32768;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed(32'($urandom_range(1048576))) - 524288;
    endcase
  endfunction

  task automatic test_extremes;
    logic signed [31:0] v[8] = '{32'sh0, 32'sh1, -32'sh1, 32'sh7fffffff,
                                 32'sh80000000, 32'sh10000, 32'sh3243f, -32'sh6487f};
    foreach (v[i]) send_twist(v[i], v[(i + 3) % 8], v[(i + 5) % 8]);
    send_twist(32'sh0, 32'sh7fffffff, 32'sh80000000);
    send_twist(32'sh2, 32'sh7fffffff, 32'sh7fffffff);
    send_twist(-32'sh2, 32'sh80000000, 32'sh7fffffff);
    send_twist(32'sh19220, 32'sh10000, -32'sh10000);
    send_twist(32'sh1921f, 32'sh10000, 32'sh10000);
  endtask

  // Tiny w just inside and just outside the band
  task automatic test_band_edges(logic [15:0] b);
    write_band(b);
    send_twist($signed({16'h0, b}), 32'sh12345, -32'sh54321);
    send_twist(-$signed({16'h0, b}), 32'sh7fffffff, 32'sh1);
    send_twist($signed({16'h0, b}) + 1, 32'sh10000, 32'sh20000);
    send_twist(-$signed({16'h0, b}) - 1, 32'sh80000000, 32'sh7fffffff);
  endtask

  task automatic test_random(int n, bit quiet);
    calm = quiet;
    repeat (n) send_twist(rand_word(), rand_word(), rand_word());
    calm = 1'b0;
  endtask

  // Stall the output side at random, except through the quiet stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  // Compare each accepted pose word with the oldest prediction
  always @(posedge clk) begin
    pose_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        $display("%0t unexpected pose: %h %h %h", $time, pose_theta, pose_x, pose_y);
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (pose_theta !== e.theta) begin
          $display("%0t theta exp %h got %h", $time, e.theta, pose_theta);
          errors++;
        end
        if (pose_x !== e.x) begin
          $display("%0t x exp %h got %h", $time, e.x, pose_x);
          errors++;
        end
        if (pose_y !== e.y) begin
          $display("%0t y exp %h got %h", $time, e.y, pose_y);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_band_edges(16'hffff);
    test_band_edges(16'h0);
    test_random(400, 1'b0);
    test_band_edges(16'h0100);
    test_random(300, 1'b1);
    test_band_edges(16'($urandom));
    test_random(500, 1'b0);
    test_band_edges(16'h0);
    test_random(580, 1'b0);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
hdl/pti_pkg.sv
hdl/pti_reduce_cell.sv
hdl/pti_cordic_cell.sv
hdl/pti_div_cell.sv
hdl/planar_twist_integrator.sv
tb/sv/tb_planar_twist_integrator.sv
